// File: design/text_line_number_and_escape_filter_macros.svh
// Assertion macros shared by the filter's modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_MACROS_SVH
`define TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge out of reset.
`define TLNEF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tlnef: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define TLNEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlnef: next-cycle check violated");

`else

`define TLNEF_ASSERT_ALWAYS(lbl, expr)
`define TLNEF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/tlnef_pkg.sv
package tlnef_pkg;

  // Line number width in BCD digits.
  localparam int NUMBER_DIGITS = 6;
  localparam int NUM_W         = 4 * NUMBER_DIGITS;

  // Output steps of one command: digits, tab, then up to four body bytes.
  localparam int BODY_MAX   = 4;
  localparam int BODY_IDX_W = 2;
  localparam int NUM_STEPS  = NUMBER_DIGITS + 1;
  localparam int STEP_W     = $clog2(NUMBER_DIGITS + 1 + BODY_MAX + 1);
  localparam int DIG_W      = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  // Command queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_MODE      = 3'd0,
    CFG_SQUEEZE_BLANK    = 3'd1,
    CFG_SHOW_ENDS        = 3'd2,
    CFG_SHOW_TABS        = 3'd3,
    CFG_SHOW_NONPRINTING = 3'd4
  } cfg_index_t;

  // Numbering modes.
  localparam logic [1:0] NUM_MODE_OFF = 2'd0;
  localparam logic [1:0] NUM_MODE_ALL = 2'd1;

  // Characters.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [6:0] CH_DEL7   = 7'h7F;
  localparam logic [3:0] ZERO_HI   = 4'h3;

  // One classified input byte, ready for expansion.
  typedef struct packed {
    logic                             has_num;
    logic [NUM_W-1:0]                 num_bcd;
    logic [BODY_MAX-1:0][7:0]         body;
    logic [BODY_IDX_W-1:0]            last_idx;
  } cmd_t;

  // Head of the command queue as seen by the expander.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// File: design/text_line_number_and_escape_filter.sv
// Byte-stream text filter with line numbering, blank-line squeezing and
// escaping of tabs, line ends and nonprinting bytes.
// Input channel: in_valid / in_stall carry one raw byte (in_data_byte) a beat.
// Output channel: out_valid / out_stall carry one rendered byte (out_byte) a
// beat; out_last_of_run marks the final byte caused by one input byte.
// A squeezed blank line produces no output beat at all.
// Configuration: cfg_wr_en, cfg_index and cfg_wdata write one register a cycle;
// write only while the filter is idle.
// An accepted input byte passes through the command queue and then the output
// register before its first beat appears. The expander emits one output beat
// per cycle while out_stall is low, so an input byte yields 1 to 11 output
// beats (7 extra when a line number is printed, up to 4 for an escaped byte).
// The input side accepts one byte a cycle while the four-entry command queue
// has room; the output rate therefore paces input. When the receiver stalls,
// the output register holds its beat, the queue fills and in_stall rises.
// Reset clears the configuration, sets the line counter to one and the
// line-start flag, and empties the queue; no initialisation pass is needed.
module text_line_number_and_escape_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [tlnef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlnef_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic                              out_last_of_run
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  tlnef_pkg::cmd_t    q_cmd;
  tlnef_pkg::q_head_t q_head;

  // Classifier and line state.
  tlnef_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Command queue between the two sides.
  tlnef_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // Byte expander and output register.
  tlnef_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: design/tlnef_front.sv
module tlnef_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [tlnef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlnef_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic                               q_full,
  output logic                               q_push,
  output tlnef_pkg::cmd_t                    q_cmd
);

  logic [1:0] number_mode_r;
  logic       squeeze_blank_r;
  logic       show_ends_r;
  logic       show_tabs_r;
  logic       show_nonprinting_r;

  logic                        at_line_start_r, at_line_start_nxt;
  logic                        prev_blank_r, prev_blank_nxt;
  logic [tlnef_pkg::NUM_W-1:0] count_r, count_nxt, count_inc;

  logic       accept;
  logic       is_nl;
  logic       squeezed;
  logic       has_num;
  logic       all_nine;
  logic       carry;
  logic [3:0] dig;
  logic [6:0] lo;
  logic [7:0] lo_a, lo_b;
  logic       lo_two;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_mode_r      <= tlnef_pkg::NUM_MODE_OFF;
      squeeze_blank_r    <= 1'b0;
      show_ends_r        <= 1'b0;
      show_tabs_r        <= 1'b0;
      show_nonprinting_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (tlnef_pkg::cfg_index_t'(cfg_index))
        tlnef_pkg::CFG_NUMBER_MODE:      number_mode_r      <= cfg_wdata;
        tlnef_pkg::CFG_SQUEEZE_BLANK:    squeeze_blank_r    <= cfg_wdata[0];
        tlnef_pkg::CFG_SHOW_ENDS:        show_ends_r        <= cfg_wdata[0];
        tlnef_pkg::CFG_SHOW_TABS:        show_tabs_r        <= cfg_wdata[0];
        tlnef_pkg::CFG_SHOW_NONPRINTING: show_nonprinting_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_nl    = (in_data_byte == tlnef_pkg::CH_NL);
  assign squeezed = is_nl && at_line_start_r && squeeze_blank_r && prev_blank_r;

  // Line state: numbering decision and blank-line tracking.
  always_comb begin
    at_line_start_nxt = at_line_start_r;
    prev_blank_nxt    = prev_blank_r;
    has_num           = 1'b0;
    if (is_nl) begin
      if (at_line_start_r) begin
        prev_blank_nxt = 1'b1;
        has_num        = (number_mode_r == tlnef_pkg::NUM_MODE_ALL);
      end
      at_line_start_nxt = 1'b1;
    end else if (at_line_start_r) begin
      prev_blank_nxt    = 1'b0;
      has_num           = (number_mode_r != tlnef_pkg::NUM_MODE_OFF);
      at_line_start_nxt = 1'b0;
    end
  end

  // BCD increment that saturates at all nines.
  always_comb begin
    all_nine  = 1'b1;
    carry     = 1'b1;
    count_inc = count_r;
    for (int i = 0; i < tlnef_pkg::NUMBER_DIGITS; i++) begin
      dig = count_r[4*i +: 4];
      if (dig != 4'd9) all_nine = 1'b0;
      if (carry) begin
        if (dig >= 4'd9) begin
          count_inc[4*i +: 4] = 4'd0;
        end else begin
          count_inc[4*i +: 4] = dig + 4'd1;
          carry = 1'b0;
        end
      end
    end
    count_nxt = (has_num && !all_nine) ? count_inc : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
      prev_blank_r    <= 1'b0;
      count_r         <= tlnef_pkg::NUM_W'(1);
    end else if (accept && !squeezed) begin
      at_line_start_r <= at_line_start_nxt;
      prev_blank_r    <= prev_blank_nxt;
      count_r         <= count_nxt;
    end
  end

  // Rendering of the low seven bits in caret notation.
  always_comb begin
    lo     = in_data_byte[6:0];
    lo_two = 1'b1;
    lo_a   = tlnef_pkg::CH_CARET;
    if (lo[6:5] == 2'b00) begin
      lo_b = {3'b010, lo[4:0]};
    end else if (lo == tlnef_pkg::CH_DEL7) begin
      lo_b = tlnef_pkg::CH_QMARK;
    end else begin
      lo_a   = {1'b0, lo};
      lo_b   = 8'h00;
      lo_two = 1'b0;
    end
  end

  // Body bytes of the command.
  always_comb begin
    q_cmd          = '0;
    q_cmd.has_num  = has_num;
    q_cmd.num_bcd  = count_r;
    if (is_nl) begin
      if (show_ends_r) begin
        q_cmd.body[0]  = tlnef_pkg::CH_DOLLAR;
        q_cmd.body[1]  = tlnef_pkg::CH_NL;
        q_cmd.last_idx = 2'd1;
      end else begin
        q_cmd.body[0]  = tlnef_pkg::CH_NL;
      end
    end else if (in_data_byte == tlnef_pkg::CH_TAB) begin
      if (show_tabs_r) begin
        q_cmd.body[0]  = tlnef_pkg::CH_CARET;
        q_cmd.body[1]  = tlnef_pkg::CH_I;
        q_cmd.last_idx = 2'd1;
      end else begin
        q_cmd.body[0]  = in_data_byte;
      end
    end else if (!show_nonprinting_r) begin
      q_cmd.body[0] = in_data_byte;
    end else if (in_data_byte[7]) begin
      q_cmd.body[0]  = tlnef_pkg::CH_M;
      q_cmd.body[1]  = tlnef_pkg::CH_DASH;
      q_cmd.body[2]  = lo_a;
      q_cmd.body[3]  = lo_b;
      q_cmd.last_idx = lo_two ? 2'd3 : 2'd2;
    end else begin
      q_cmd.body[0]  = lo_a;
      q_cmd.body[1]  = lo_b;
      q_cmd.last_idx = lo_two ? 2'd1 : 2'd0;
    end
  end

  assign q_push = accept && !squeezed;

endmodule

// File: design/tlnef_queue.sv
`include "text_line_number_and_escape_filter_macros.svh"

module tlnef_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tlnef_pkg::cmd_t    push_cmd,
  output logic               full,
  input  logic               pop,
  output tlnef_pkg::q_head_t head
);

  tlnef_pkg::cmd_t                mem [tlnef_pkg::Q_DEPTH];
  logic [tlnef_pkg::Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [tlnef_pkg::Q_CNT_W-1:0]  count_r, count_nxt;
  logic                           empty;

  assign empty = (count_r == '0);
  assign full  = (count_r == tlnef_pkg::Q_CNT_W'(tlnef_pkg::Q_DEPTH));

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign head.valid = !empty;
  assign head.cmd   = mem[rd_ptr_r];

  `TLNEF_ASSERT_ALWAYS(q_no_overflow, !(push && full))
  `TLNEF_ASSERT_ALWAYS(q_no_underflow, !(pop && empty))

endmodule

// File: design/tlnef_back.sv
`include "text_line_number_and_escape_filter_macros.svh"

module tlnef_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tlnef_pkg::q_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run
);

  localparam logic [tlnef_pkg::STEP_W-1:0] NumSteps =
    tlnef_pkg::STEP_W'(tlnef_pkg::NUM_STEPS);
  localparam logic [tlnef_pkg::STEP_W-1:0] TabStep =
    tlnef_pkg::STEP_W'(tlnef_pkg::NUMBER_DIGITS);

  logic [tlnef_pkg::STEP_W-1:0] pos_r, pos_nxt;
  logic [tlnef_pkg::STEP_W-1:0] eff, body_off;
  logic                         in_body;
  logic                         is_last;
  logic                         load;
  logic                         started;
  logic [3:0]                   dig;
  logic [7:0]                   chars [tlnef_pkg::NUMBER_DIGITS];
  logic [7:0]                   cur_byte;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  // Step within the current command; the number steps are skipped when absent.
  assign eff      = head.cmd.has_num ? pos_r : pos_r + NumSteps;
  assign body_off = eff - NumSteps;
  assign in_body  = (eff >= NumSteps);
  assign is_last  = in_body && (body_off[tlnef_pkg::BODY_IDX_W-1:0] == head.cmd.last_idx);

  // Line number characters, most significant first, leading zeros as spaces.
  always_comb begin
    started = 1'b0;
    for (int i = 0; i < tlnef_pkg::NUMBER_DIGITS; i++) begin
      dig = head.cmd.num_bcd[4*(tlnef_pkg::NUMBER_DIGITS-1-i) +: 4];
      if (dig != 4'd0 || i == tlnef_pkg::NUMBER_DIGITS - 1) started = 1'b1;
      chars[i] = started ? {tlnef_pkg::ZERO_HI, dig} : tlnef_pkg::CH_SPACE;
    end
  end

  always_comb begin
    if (in_body) begin
      cur_byte = head.cmd.body[body_off[tlnef_pkg::BODY_IDX_W-1:0]];
    end else if (eff == TabStep) begin
      cur_byte = tlnef_pkg::CH_TAB;
    end else begin
      cur_byte = chars[eff[tlnef_pkg::DIG_W-1:0]];
    end
  end

  assign load = head.valid && (!out_valid_r || !out_stall);
  assign pop  = load && is_last;

  always_comb begin
    pos_nxt = pos_r;
    if (load) pos_nxt = is_last ? '0 : pos_r + 1'b1;
  end

  // Output register: a queued beat loads whenever the slot is free or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  `TLNEF_ASSERT_ALWAYS(bk_body_in_range,
    !(head.valid && in_body) || (body_off < tlnef_pkg::STEP_W'(tlnef_pkg::BODY_MAX)))
  `TLNEF_ASSERT_NEXT(bk_pos_rewinds, pop, pos_r == '0)

endmodule
